@@ rtl/brm_pkg.sv @@
package brm_pkg;

  localparam int unsigned ProgSlotsDef = 32;
  localparam int unsigned RegCountDef  = 16;

  // Instruction opcodes
  localparam logic [7:0] OpInc   = 8'h01;
  localparam logic [7:0] OpDec   = 8'h02;
  localparam logic [7:0] OpMov   = 8'h03;
  localparam logic [7:0] OpLdi   = 8'h04;
  localparam logic [7:0] OpShl   = 8'h05;
  localparam logic [7:0] OpShr   = 8'h06;
  localparam logic [7:0] OpJmp   = 8'h07;
  localparam logic [7:0] OpJz    = 8'h08;
  localparam logic [7:0] OpJnz   = 8'h09;
  localparam logic [7:0] OpJend  = 8'h0A;
  localparam logic [7:0] OpHalt  = 8'h0B;
  localparam logic [7:0] OpSub   = 8'h0D;
  localparam logic [7:0] OpXor   = 8'h0E;
  localparam logic [7:0] OpOr    = 8'h0F;
  localparam logic [7:0] OpRead  = 8'h10;
  localparam logic [7:0] OpWrite = 8'h11;

  // State updates produced by one executed instruction
  typedef struct packed {
    logic       wr_en;
    logic [3:0] wr_addr;
    logic [7:0] wr_data;
    logic       set_zero;
    logic       set_end;
    logic       set_stop;
  } brm_upd_t;

  // One result item
  typedef struct packed {
    logic [4:0] next_pc;
    logic       halted;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       in_taken;
  } brm_res_t;

endpackage

@@ rtl/brm_exec.sv @@
module brm_exec
  import brm_pkg::*;
#(
  parameter int unsigned PROG_SLOTS = ProgSlotsDef,
  localparam int unsigned PcW = $clog2(PROG_SLOTS)
) (
  input  logic [7:0]     opcode_i,
  input  logic [7:0]     operand_i,
  input  logic [7:0]     in_byte_i,
  input  logic           in_exhausted_i,
  input  logic [7:0]     rx_i,
  input  logic [7:0]     ry_i,
  input  logic           zero_i,
  input  logic           end_i,
  input  logic           stop_i,
  input  logic [PcW-1:0] pc_i,
  output brm_upd_t       upd_o,
  output logic [PcW-1:0] pc_o,
  output brm_res_t       res_o
);

  localparam logic signed [9:0] SlotsS = 10'(PROG_SLOTS);

  logic              jump;
  logic              leave;
  logic [7:0]        pc8;
  logic [4:0]        pc5;
  logic signed [9:0] offset;
  logic signed [9:0] target;

  // Jump decision from opcode and flags only
  always_comb begin
    case (opcode_i)
      OpJmp:   jump = 1'b1;
      OpJz:    jump = zero_i;
      OpJnz:   jump = !zero_i;
      OpJend:  jump = end_i;
      default: jump = 1'b0;
    endcase
  end

  assign pc8    = 8'(pc_i);
  assign offset = jump ? $signed({{2{operand_i[7]}}, operand_i}) : 10'sd1;
  assign target = $signed({2'b00, pc8}) + offset;
  assign leave  = (target < 10'sd0) || (target >= SlotsS);

  // Hold the counter when stopped, on halt, or when the target leaves the program
  assign pc_o   = (stop_i || (opcode_i == OpHalt) || leave) ? pc_i : target[PcW-1:0];
  assign pc5    = 5'(pc_o);

  always_comb begin
    upd_o           = '0;
    upd_o.wr_addr   = operand_i[3:0];
    res_o           = '0;
    if (!stop_i) begin
      case (opcode_i)
        OpInc: begin
          upd_o.wr_en    = 1'b1;
          upd_o.wr_data  = rx_i + 8'd1;
          upd_o.set_zero = (rx_i == 8'd0);
        end
        OpDec: begin
          upd_o.wr_en    = 1'b1;
          upd_o.wr_data  = rx_i - 8'd1;
          upd_o.set_zero = (rx_i == 8'd0);
        end
        OpMov: begin
          upd_o.wr_en   = 1'b1;
          upd_o.wr_data = ry_i;
        end
        OpLdi: begin
          upd_o.wr_en   = 1'b1;
          upd_o.wr_addr = 4'd0;
          upd_o.wr_data = operand_i;
        end
        OpShl: begin
          upd_o.wr_en   = 1'b1;
          upd_o.wr_data = {rx_i[6:0], 1'b0};
        end
        OpShr: begin
          upd_o.wr_en   = 1'b1;
          upd_o.wr_data = {1'b0, rx_i[7:1]};
        end
        OpSub: begin
          upd_o.wr_en   = 1'b1;
          upd_o.wr_data = rx_i - ry_i;
        end
        OpXor: begin
          upd_o.wr_en   = 1'b1;
          upd_o.wr_data = rx_i ^ ry_i;
        end
        OpOr: begin
          upd_o.wr_en   = 1'b1;
          upd_o.wr_data = rx_i | ry_i;
        end
        OpHalt: upd_o.set_stop = 1'b1;
        OpRead: begin
          if (in_exhausted_i) begin
            upd_o.set_end = 1'b1;
          end else begin
            upd_o.wr_en    = 1'b1;
            upd_o.wr_data  = in_byte_i;
            res_o.in_taken = 1'b1;
          end
        end
        OpWrite: begin
          res_o.out_valid = 1'b1;
          res_o.out_byte  = rx_i;
        end
        default: ;
      endcase

      // result-zero check for the shift and two-operand ALU ops
      if (opcode_i inside {OpShl, OpShr, OpSub, OpXor, OpOr}) begin
        upd_o.set_zero = (upd_o.wr_data == 8'd0);
      end

      if (leave) begin
        upd_o.set_stop = 1'b1;
      end
    end
    res_o.next_pc = pc5;
    res_o.halted  = stop_i | upd_o.set_stop;
  end

endmodule

@@ rtl/byte_register_machine_execute_top.sv @@
// Channel   | Dir | Fields (lowest bit first)
// ----------+-----+--------------------------------------------------------
// s_axis    | in  | tdata: opcode[7:0] operand[15:8] in_byte[23:16]
//           |     | tuser: in_exhausted[0]
// m_axis    | out | tdata: next_pc[4:0] out_byte[12:5], zero pad [15:13]
//           |     | tuser: halted[0] out_valid[1] in_taken[2]
//
// Each instruction transaction is captured with its two source registers
// (read from the register file on the same edge), executed combinationally and
// lands in the output register; one transaction per cycle is sustained while
// m_axis accepts results. The execute stage sets the rate: state from one
// instruction is written at the edge the next one executes.
// Reset clears the valid bits of the register file, so all registers read
// as zero, along with the flags, the program counter and both stage valids.
// A stalled m_axis holds the result; one more transaction can still be
// captured behind it before s_axis_tready drops.
module byte_register_machine_execute_top
  import brm_pkg::*;
#(
  parameter int unsigned PROG_SLOTS = ProgSlotsDef,
  parameter int unsigned REG_COUNT  = RegCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // opcode, operand, in_byte
  input  logic [0:0]  s_axis_tuser,   // in_exhausted
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // next_pc, out_byte, zero pad
  output logic [2:0]  m_axis_tuser    // halted, out_valid, in_taken
);

  localparam int unsigned PcW = $clog2(PROG_SLOTS);
  localparam int unsigned RaW = $clog2(REG_COUNT);

  // Register file with per-entry valid bits: an unwritten entry reads zero
  logic [7:0]           rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0] rf_vld_q;

  // Capture stage
  logic       in_vld_q;
  logic [7:0] opcode_q, operand_q, in_byte_q, rx_q, ry_q;
  logic       in_exh_q;

  // Architectural state
  logic           zero_q, end_q, stop_q;
  logic [PcW-1:0] pc_q, pc_d;

  // Output register
  logic     out_vld_q;
  brm_res_t res_q, res_d;
  brm_upd_t upd;

  logic           s_hs, advance, out_free;
  logic [RaW-1:0] x_in, y_in, wr_idx;
  logic           wr_fire;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign advance       = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || advance;
  assign s_hs          = s_axis_tvalid && s_axis_tready;

  assign x_in    = s_axis_tdata[8 +: RaW];
  assign y_in    = s_axis_tdata[12 +: RaW];
  assign wr_idx  = upd.wr_addr[RaW-1:0];
  assign wr_fire = advance && upd.wr_en;

  brm_exec #(
    .PROG_SLOTS(PROG_SLOTS)
  ) u_exec (
    .opcode_i      (opcode_q),
    .operand_i     (operand_q),
    .in_byte_i     (in_byte_q),
    .in_exhausted_i(in_exh_q),
    .rx_i          (rx_q),
    .ry_i          (ry_q),
    .zero_i        (zero_q),
    .end_i         (end_q),
    .stop_i        (stop_q),
    .pc_i          (pc_q),
    .upd_o         (upd),
    .pc_o          (pc_d),
    .res_o         (res_d)
  );

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      rf_mem[wr_idx] <= upd.wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
    end else if (wr_fire) begin
      rf_vld_q[wr_idx] <= 1'b1;
    end
  end

  // Capture payload and read both sources; forward the write landing on
  // the same edge so the captured operands are never stale
  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      opcode_q  <= s_axis_tdata[7:0];
      operand_q <= s_axis_tdata[15:8];
      in_byte_q <= s_axis_tdata[23:16];
      in_exh_q  <= s_axis_tuser[0];
      if (wr_fire && wr_idx == x_in) begin
        rx_q <= upd.wr_data;
      end else begin
        rx_q <= rf_vld_q[x_in] ? rf_mem[x_in] : 8'd0;
      end
      if (wr_fire && wr_idx == y_in) begin
        ry_q <= upd.wr_data;
      end else begin
        ry_q <= rf_vld_q[y_in] ? rf_mem[y_in] : 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      zero_q    <= 1'b0;
      end_q     <= 1'b0;
      stop_q    <= 1'b0;
      pc_q      <= '0;
    end else begin
      if (s_hs) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        zero_q    <= zero_q | upd.set_zero;
        end_q     <= end_q | upd.set_end;
        stop_q    <= stop_q | upd.set_stop;
        pc_q      <= pc_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, res_q.out_byte, res_q.next_pc};
  assign m_axis_tuser  = {res_q.in_taken, res_q.out_valid, res_q.halted};

`ifndef SYNTHESIS
  // Once stopped, the machine stays stopped
  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |=> stop_q)
    else $error("stop flag cleared");

  // A stopped machine never writes its register file
  a_no_write_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_fire |-> !stop_q)
    else $error("register write while stopped");

  // The program counter is frozen once stopped
  a_pc_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |=> $stable(pc_q))
    else $error("program counter moved while stopped");

  // Input side only stalls when the capture stage is full and blocked
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_vld_q && out_vld_q && !m_axis_tready))
    else $error("input stalled without a blocked result");

  // A stopped machine reports halted and no side effects
  a_stopped_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && stop_q) |=> (res_q.halted && !res_q.out_valid && !res_q.in_taken))
    else $error("stopped machine produced side effects");
`endif

endmodule

@@ dv/byte_register_machine_execute_top_tb.sv @@
module byte_register_machine_execute_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import brm_pkg::*;

  localparam int unsigned CLK_PERIOD = 10;
  localparam int unsigned PROG_SLOTS = ProgSlotsDef;
  localparam int unsigned RAND_ITEMS = 720;
  localparam int unsigned AFTER_STOP = 12;
  localparam int unsigned IDLE_PCT   = 26;
  localparam int unsigned QUIET_FROM = 300;   // no random idling on either side here
  localparam int unsigned QUIET_TO   = 800;
  localparam int unsigned HOLD_AT    = 200;   // result count that starts the long hold-off
  localparam int unsigned HOLD_LEN   = 80;
  localparam int unsigned DRAIN_CYC  = 8;
  localparam int unsigned STALL_MAX  = 1000;
  localparam int unsigned MAX_REPORT = 10;

  // Opcodes the block does not decode
  localparam logic [7:0] OpUnkLow  = 8'h00;
  localparam logic [7:0] OpUnkGap  = 8'h0C;
  localparam logic [7:0] OpUnkHigh = 8'hFF;

  localparam logic [7:0] KNOWN_OPS [16] = '{
    OpInc, OpDec, OpMov, OpLdi, OpShl, OpShr, OpJmp, OpJz,
    OpJnz, OpJend, OpHalt, OpSub, OpXor, OpOr, OpRead, OpWrite
  };

  // One instruction transaction; opcode sits in the low byte, in_exhausted on top
  typedef struct packed {
    logic       exhausted;
    logic [7:0] in_byte;
    logic [7:0] operand;
    logic [7:0] opcode;
  } instr_t;

  typedef struct packed {
    logic [15:0][7:0] regs;
    logic             zflag;
    logic             eflag;
    logic [4:0]       pc;
    logic             stop;
  } mach_state_t;

  typedef struct packed {
    mach_state_t st;
    brm_res_t    res;
  } exec_out_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // opcode[7:0] operand[15:8] in_byte[23:16]
  logic [0:0]  s_axis_tuser  = '0;   // in_exhausted[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // next_pc[4:0] out_byte[12:5] zero pad[15:13]
  logic [2:0]  m_axis_tuser;         // halted[0] out_valid[1] in_taken[2]

  instr_t      program_q [$];        // instructions still to be offered
  brm_res_t    due_results [$];      // predicted results, oldest first
  instr_t      cur_instr;            // instruction currently on s_axis
  mach_state_t model_state = '0;     // machine as seen by accepted transactions
  mach_state_t gen_state   = '0;     // machine as seen by the program generator

  int unsigned cyc       = 0;
  int unsigned n_recv    = 0;
  int unsigned n_err     = 0;
  int unsigned stall_cnt = 0;
  int unsigned hold_cnt  = 0;
  logic        hold_done = 1'b0;

  wire quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

  byte_register_machine_execute_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Execute one instruction on a copy of the machine; return new state and result
  function automatic exec_out_t exec_instr(mach_state_t st, instr_t it);
    exec_out_t o;
    logic [3:0] x;
    logic [3:0] y;
    logic [7:0] rx;
    logic [7:0] ry;
    logic [7:0] alu;
    logic       alu_wr;
    logic       take;
    int         tgt;
    o      = '0;
    o.st   = st;
    x      = it.operand[3:0];
    y      = it.operand[7:4];
    rx     = st.regs[x];
    ry     = st.regs[y];
    alu    = '0;
    alu_wr = 1'b0;
    take   = 1'b0;
    if (!st.stop) begin
      case (it.opcode)
        OpInc: begin
          if (rx == 8'h00) o.st.zflag = 1'b1;
          o.st.regs[x] = rx + 8'd1;
        end
        OpDec: begin
          if (rx == 8'h00) o.st.zflag = 1'b1;
          o.st.regs[x] = rx - 8'd1;
        end
        OpMov:  o.st.regs[x] = ry;
        OpLdi:  o.st.regs[0] = it.operand;
        OpShl:  begin alu = rx << 1;  alu_wr = 1'b1; end
        OpShr:  begin alu = rx >> 1;  alu_wr = 1'b1; end
        OpSub:  begin alu = rx - ry;  alu_wr = 1'b1; end
        OpXor:  begin alu = rx ^ ry;  alu_wr = 1'b1; end
        OpOr:   begin alu = rx | ry;  alu_wr = 1'b1; end
        OpJmp:  take = 1'b1;
        OpJz:   take = st.zflag;
        OpJnz:  take = !st.zflag;
        OpJend: take = st.eflag;
        OpHalt: o.st.stop = 1'b1;
        OpRead: begin
          if (it.exhausted) begin
            o.st.eflag = 1'b1;
          end else begin
            o.st.regs[x]  = it.in_byte;
            o.res.in_taken = 1'b1;
          end
        end
        OpWrite: begin
          o.res.out_valid = 1'b1;
          o.res.out_byte  = rx;
        end
        default: ;
      endcase
      if (alu_wr) begin
        o.st.regs[x] = alu;
        if (alu == 8'h00) o.st.zflag = 1'b1;
      end
      if (!o.st.stop) begin
        // taken jumps add the operand as a signed offset
        tgt = int'(st.pc) + (take ? int'($signed(it.operand)) : 1);
        if (tgt < 0 || tgt >= int'(PROG_SLOTS)) o.st.stop = 1'b1;
        else o.st.pc = tgt[4:0];
      end
    end
    o.res.next_pc = o.st.pc;
    o.res.halted  = o.st.stop;
    return o;
  endfunction

  function automatic instr_t mk_instr(logic [7:0] op, logic [7:0] arg,
                                      logic [7:0] inb = 8'h00, logic exh = 1'b0);
    instr_t it;
    it.opcode    = op;
    it.operand   = arg;
    it.in_byte   = inb;
    it.exhausted = exh;
    return it;
  endfunction

  // Random instruction; most jump offsets aim at a random slot inside the program
  function automatic instr_t rand_instr(mach_state_t st);
    instr_t      it;
    int unsigned slot;
    it.opcode    = ($urandom_range(0, 99) < 15) ? 8'($urandom)
                                                : KNOWN_OPS[$urandom_range(0, 15)];
    it.operand   = 8'($urandom);
    it.in_byte   = 8'($urandom);
    it.exhausted = ($urandom_range(0, 99) < 15);
    if (it.opcode >= OpJmp && it.opcode <= OpJend && $urandom_range(0, 9) != 0) begin
      slot       = $urandom_range(0, PROG_SLOTS - 1);
      it.operand = 8'(slot - st.pc);
    end
    return it;
  endfunction

  // Append to the program and advance the generator's view of the machine
  task automatic add_instr(instr_t it);
    exec_out_t o;
    o         = exec_instr(gen_state, it);
    gen_state = o.st;
    program_q.push_back(it);
  endtask

  // Driver: offer instructions, predict each one at its accepting edge
  always @(posedge clk_i or negedge rst_ni) begin
    exec_out_t o;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        o           = exec_instr(model_state, cur_instr);
        model_state = o.st;
        due_results.push_back(o.res);
      end
      // load the next instruction once the bus is free; hold it otherwise
      if (!s_axis_tvalid || s_axis_tready) begin
        if (program_q.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_instr = program_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= cur_instr[23:0];
          s_axis_tuser  <= cur_instr.exhausted;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random backpressure plus one long hold-off to fill the pipeline
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= 0;
      hold_done     <= 1'b0;
    end else if (hold_cnt != 0) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= hold_cnt - 1;
    end else if (!hold_done && n_recv >= HOLD_AT) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= HOLD_LEN;
      hold_done     <= 1'b1;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Monitor: compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    brm_res_t got;
    brm_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.next_pc   = m_axis_tdata[4:0];
      got.out_byte  = m_axis_tdata[12:5];
      got.halted    = m_axis_tuser[0];
      got.out_valid = m_axis_tuser[1];
      got.in_taken  = m_axis_tuser[2];
      n_recv <= n_recv + 1;
      if (due_results.size() == 0) begin
        if (n_err < MAX_REPORT)
          $display("[%0t] unexpected result: pc=%0d halted=%0b out_valid=%0b out_byte=%02h in_taken=%0b",
                   $realtime, got.next_pc, got.halted, got.out_valid, got.out_byte,
                   got.in_taken);
        n_err = n_err + 1;
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          if (n_err < MAX_REPORT)
            $display("[%0t] result %0d: pc %0d/%0d halted %0b/%0b out_valid %0b/%0b out_byte %02h/%02h in_taken %0b/%0b (exp/got)",
                     $realtime, n_recv, want.next_pc, got.next_pc, want.halted, got.halted,
                     want.out_valid, got.out_valid, want.out_byte, got.out_byte,
                     want.in_taken, got.in_taken);
          n_err = n_err + 1;
        end
      end
    end
  end

  // Cycle count and watchdog on handshake activity
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cnt <= 0;
      else
        stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_MAX) begin
        $display("[%0t] no transaction for %0d cycles", $realtime, stall_cnt);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    instr_t    it;
    exec_out_t trial;
    int        mode;

    // Directed opening: flags still clear, so conditional jumps go both ways first
    add_instr(mk_instr(OpJnz,   8'h02));           // taken: zero flag clear
    add_instr(mk_instr(OpJz,    8'h05));           // not taken
    add_instr(mk_instr(OpJend,  8'h05));           // not taken
    add_instr(mk_instr(OpLdi,   8'hFF));
    add_instr(mk_instr(OpMov,   8'h0F));           // r15 = r0
    add_instr(mk_instr(OpInc,   8'h0F));           // wraps to zero, flag stays clear
    add_instr(mk_instr(OpShl,   8'h00));
    add_instr(mk_instr(OpShr,   8'h00));
    add_instr(mk_instr(OpXor,   8'hF0));
    add_instr(mk_instr(OpOr,    8'h01));
    add_instr(mk_instr(OpSub,   8'h10));           // zero result sets the flag
    add_instr(mk_instr(OpJz,    8'hFE));           // taken backward
    add_instr(mk_instr(OpJnz,   8'h05));           // not taken
    add_instr(mk_instr(OpRead,  8'h02, 8'hFF, 1'b0));
    add_instr(mk_instr(OpWrite, 8'h02));
    add_instr(mk_instr(OpRead,  8'h03, 8'hAA, 1'b1)); // input exhausted: end flag
    add_instr(mk_instr(OpJend,  8'h03));           // taken
    add_instr(mk_instr(OpDec,   8'h04));           // zero wraps to 0xFF
    add_instr(mk_instr(OpUnkHigh, 8'h00));
    add_instr(mk_instr(OpUnkGap,  8'hFF));
    add_instr(mk_instr(OpUnkLow,  8'h5A));
    add_instr(mk_instr(OpWrite, 8'h0F));
    add_instr(mk_instr(OpJmp,   8'(-int'(gen_state.pc))));   // back to slot zero

    // Random program: redraw any instruction that would stop the machine
    for (int i = 0; i < RAND_ITEMS; i++) begin
      do begin
        it    = rand_instr(gen_state);
        trial = exec_instr(gen_state, it);
      end while (trial.res.halted);
      add_instr(it);
    end

    // Stop the machine: halt opcode, a write that runs off the end, or a wild jump
    mode = $urandom_range(0, 2);
    case (mode)
      0: add_instr(mk_instr(OpHalt, 8'($urandom)));
      1: begin
        add_instr(mk_instr(OpJmp, 8'(PROG_SLOTS - 1 - gen_state.pc)));
        add_instr(mk_instr(OpWrite, 8'($urandom)));
      end
      default: add_instr(mk_instr(OpJmp, $urandom_range(0, 1) ? 8'h80 : 8'h7F));
    endcase

    // Once stopped, nothing may change
    add_instr(mk_instr(OpWrite, 8'($urandom)));
    add_instr(mk_instr(OpRead, 8'($urandom), 8'($urandom), 1'b0));
    for (int i = 0; i < AFTER_STOP; i++) add_instr(rand_instr(gen_state));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (program_q.size() != 0 || s_axis_tvalid);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (n_err == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
